FILE: rtl/cfta_pkg.sv
// shared types, character constants and hex digit helper for the frame text encoder
`default_nettype none
package cfta_pkg;

    localparam int NIB_W           = 4;
    localparam int PAYLOAD_BYTES   = 8;
    localparam int HEAD_NIBBLES    = 4;
    localparam int FRAME_NIBBLES   = HEAD_NIBBLES + 2 * PAYLOAD_BYTES;
    localparam int FRAME_W         = FRAME_NIBBLES * NIB_W;
    localparam int DEF_MAX_PAYLOAD = 8;

    localparam logic [7:0] CHAR_T  = 8'h74;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_A  = 8'h41;
    localparam logic [7:0] CHAR_0  = 8'h30;
    localparam logic [3:0] NIB_TEN = 4'd10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HEAD,
        ST_DIGIT,
        ST_TAIL
    } seq_state_t;

    typedef struct packed {
        logic load;
        logic shift;
    } seq_ctl_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib >= NIB_TEN) begin
            ch = CHAR_A + {4'b0, nib - NIB_TEN};
        end else begin
            ch = CHAR_0 + {4'b0, nib};
        end
        return ch;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/cfta_shifter.sv
// nibble shift register holding identifier, length code and payload of one frame
`default_nettype none
module cfta_shifter (
    input  wire logic                  aclk,
    input  wire cfta_pkg::seq_ctl_t    ctl,
    input  wire logic [11:0]           frame_id,
    input  wire logic [3:0]            length_code,
    input  wire logic [7:0]            byte0,
    input  wire logic [7:0]            byte1,
    input  wire logic [7:0]            byte2,
    input  wire logic [7:0]            byte3,
    input  wire logic [7:0]            byte4,
    input  wire logic [7:0]            byte5,
    input  wire logic [7:0]            byte6,
    input  wire logic [7:0]            byte7,
    output logic [cfta_pkg::NIB_W-1:0] nibble
);
    import cfta_pkg::*;

    logic [FRAME_W-1:0] data_reg;
    logic [FRAME_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (ctl.load) begin
            data_next = {frame_id, length_code, byte0, byte1, byte2, byte3,
                         byte4, byte5, byte6, byte7};
        end else if (ctl.shift) begin
            data_next = {data_reg[FRAME_W-NIB_W-1:0], {NIB_W{1'b0}}};
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign nibble = data_reg[FRAME_W-1 -: NIB_W];

endmodule
`default_nettype wire

FILE: rtl/cfta_seq.sv
// sequencer: walks the frame text one character per output slot
`default_nettype none
module cfta_seq #(
    parameter int MAX_PAYLOAD = cfta_pkg::DEF_MAX_PAYLOAD
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    input  wire logic [3:0]            s_length_code,
    input  wire logic [cfta_pkg::NIB_W-1:0] nibble,
    input  wire logic                  adv,
    output logic                       s_ready,
    output cfta_pkg::seq_ctl_t         ctl,
    output logic                       emit_valid,
    output logic [7:0]                 emit_char,
    output logic                       emit_last
);
    import cfta_pkg::*;

    localparam int DIG_W = $clog2(HEAD_NIBBLES + 2 * MAX_PAYLOAD + 1);

    seq_state_t       state_reg;
    seq_state_t       state_next;
    logic [DIG_W-1:0] cnt_reg;
    logic [DIG_W-1:0] cnt_next;
    logic [3:0]       pay_cnt;

    // payload byte count saturates at the limit
    assign pay_cnt = (s_length_code > 4'(MAX_PAYLOAD)) ? 4'(MAX_PAYLOAD) : s_length_code;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        s_ready    = 1'b0;
        ctl        = '0;
        emit_valid = 1'b0;
        emit_char  = CHAR_T;
        emit_last  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctl.load   = 1'b1;
                    cnt_next   = DIG_W'({pay_cnt, 1'b0}) + DIG_W'(HEAD_NIBBLES);
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD: begin
                if (adv) begin
                    emit_valid = 1'b1;
                    emit_char  = CHAR_T;
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (adv) begin
                    emit_valid = 1'b1;
                    emit_char  = hex_char(nibble);
                    ctl.shift  = 1'b1;
                    cnt_next   = cnt_reg - DIG_W'(1);
                    if (cnt_reg == DIG_W'(1)) begin
                        state_next = ST_TAIL;
                    end
                end
            end
            ST_TAIL: begin
                if (adv) begin
                    emit_valid = 1'b1;
                    emit_char  = CHAR_CR;
                    emit_last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_to_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_HEAD))
        else $error("accepted frame did not start its text");

    a_digit_cnt_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIGIT) |-> (cnt_reg != '0))
        else $error("digit state with no digits left");

    a_emit_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_valid |-> adv)
        else $error("character produced without output room");
`endif

endmodule
`default_nettype wire

FILE: rtl/can_frame_to_ascii_hex_top.sv
// top level: frame text encoder with registered character output
// after a frame word is accepted the sequencer enters its head state, then the 't' goes into the output register
// one character per cycle while m_ready holds; a frame is 6 + 2 * min(length, MAX_PAYLOAD) characters
// the sequencer shifts out one nibble per unstalled cycle and takes the next word only when idle
// reset (aresetn low, synchronous) returns the sequencer to idle and empties the output register
`default_nettype none
module can_frame_to_ascii_hex_top #(
    parameter int MAX_PAYLOAD = cfta_pkg::DEF_MAX_PAYLOAD
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [11:0] s_frame_id,
    input  wire logic [3:0]  s_length_code,
    input  wire logic [7:0]  s_byte0,
    input  wire logic [7:0]  s_byte1,
    input  wire logic [7:0]  s_byte2,
    input  wire logic [7:0]  s_byte3,
    input  wire logic [7:0]  s_byte4,
    input  wire logic [7:0]  s_byte5,
    input  wire logic [7:0]  s_byte6,
    input  wire logic [7:0]  s_byte7,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_ascii_char,
    output logic             m_last_char
);
    import cfta_pkg::*;

    seq_ctl_t         ctl;
    logic [NIB_W-1:0] nibble;
    logic             adv;
    logic             emit_valid;
    logic [7:0]       emit_char;
    logic             emit_last;

    logic       m_valid_reg;
    logic       m_valid_next;
    logic [7:0] m_char_reg;
    logic       m_last_reg;

    assign adv = !m_valid_reg || m_ready;

    cfta_shifter u_shifter (
        .aclk        (aclk),
        .ctl         (ctl),
        .frame_id    (s_frame_id),
        .length_code (s_length_code),
        .byte0       (s_byte0),
        .byte1       (s_byte1),
        .byte2       (s_byte2),
        .byte3       (s_byte3),
        .byte4       (s_byte4),
        .byte5       (s_byte5),
        .byte6       (s_byte6),
        .byte7       (s_byte7),
        .nibble      (nibble)
    );

    cfta_seq #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_length_code (s_length_code),
        .nibble        (nibble),
        .adv           (adv),
        .s_ready       (s_ready),
        .ctl           (ctl),
        .emit_valid    (emit_valid),
        .emit_char     (emit_char),
        .emit_last     (emit_last)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit_valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (emit_valid) begin
            m_char_reg <= emit_char;
            m_last_reg <= emit_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_ascii_char = m_char_reg;
    assign m_last_char  = m_last_reg;

endmodule
`default_nettype wire
